// ===== sv/mhc_pkg.sv =====
`default_nettype none
package mhc_pkg;

	localparam logic [31:0] MAGIC_RESET = 32'hd9b4bef9;
	localparam logic [31:0] EMPTY_CKS = 32'he2e0f65d;
	localparam logic [4:0] HDR_BYTES = 5'd24;

	// result status codes
	localparam logic [2:0] ST_GOOD = 3'd0;
	localparam logic [2:0] ST_MAGIC = 3'd1;
	localparam logic [2:0] ST_LENGTH = 3'd2;
	localparam logic [2:0] ST_CKS = 3'd3;
	localparam logic [2:0] ST_SHORT = 3'd4;

	// padding byte select
	localparam logic [1:0] PAD_80 = 2'd0;
	localparam logic [1:0] PAD_ZERO = 2'd1;
	localparam logic [1:0] PAD_LEN = 2'd2;

	localparam logic [31:0] SHA_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic take_byte;
		logic pad_shift;
		logic [1:0] pad_sel;
		logic start;
		logic round;
		logic [5:0] rnd;
		logic finish;
		logic load2;
		logic load_out;
		logic [2:0] status;
		logic clear;
	} mhc_cmd_t;

	typedef struct packed {
		logic hdr_done;
		logic blk_last;
		logic blk_at_len;
		logic short_hdr;
		logic magic_bad;
		logic len_bad;
		logic empty;
		logic cks_match;
	} mhc_sts_t;

endpackage
`default_nettype wire

// ===== sv/mhc_datapath.sv =====
`default_nettype none
module mhc_datapath
	import mhc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data,
	input wire logic [7:0] data_byte,
	input wire mhc_cmd_t cmd,
	output mhc_sts_t sts,
	output logic [2:0] status,
	output logic [31:0] payload_length,
	output logic [31:0] received_checksum,
	output logic [31:0] computed_checksum
);

	logic [31:0] netmagic_q;
	logic [4:0] hdr_pos_q;
	logic [31:0] magic_q, dlen_q, dcks_q;
	logic [63:0] count_q;
	logic [5:0] blk_pos_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];

	logic hdr_done;
	logic [7:0] shift_byte;
	logic [63:0] len_sh;
	logic [31:0] s0, s1, w_new, t1, t2, big0, big1, ch, maj;
	logic [31:0] cks_calc;

	assign hdr_done = (hdr_pos_q == HDR_BYTES);
	assign len_sh = {count_q[60:0], 3'b000} << {blk_pos_q[2:0], 3'b000};

	always_comb begin
		case (cmd.pad_sel)
			PAD_80: shift_byte = 8'h80;
			PAD_LEN: shift_byte = len_sh[63:56];
			default: shift_byte = 8'h00;
		endcase
		if (cmd.take_byte) shift_byte = data_byte;
	end

	// message schedule and round function
	assign s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
	assign s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]};
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + big1 + ch + SHA_K[cmd.rnd] + w_q[0];
	assign big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]};
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = big0 + maj;

	assign cks_calc = (count_q == 64'd0) ? EMPTY_CKS
		: {h_q[0][7:0], h_q[0][15:8], h_q[0][23:16], h_q[0][31:24]};

	always_comb begin
		sts.hdr_done = hdr_done;
		sts.blk_last = (blk_pos_q == 6'd63);
		sts.blk_at_len = (blk_pos_q == 6'd56);
		sts.short_hdr = !hdr_done;
		sts.magic_bad = (magic_q != netmagic_q);
		sts.len_bad = ({32'd0, dlen_q} != count_q);
		sts.empty = (count_q == 64'd0);
		sts.cks_match = (cks_calc == dcks_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			netmagic_q <= MAGIC_RESET;
			hdr_pos_q <= '0;
			magic_q <= '0;
			dlen_q <= '0;
			dcks_q <= '0;
			count_q <= '0;
			blk_pos_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= SHA_INIT[i];
		end else begin
			if (cfg_wr_en) netmagic_q <= cfg_wr_data;
			if (cmd.clear) begin
				hdr_pos_q <= '0;
				magic_q <= '0;
				dlen_q <= '0;
				dcks_q <= '0;
				count_q <= '0;
				blk_pos_q <= '0;
				for (int i = 0; i < 8; i++) h_q[i] <= SHA_INIT[i];
			end else begin
				if (cmd.take_byte && !hdr_done) begin
					hdr_pos_q <= hdr_pos_q + 5'd1;
					if (hdr_pos_q < 5'd4)
						magic_q[{hdr_pos_q[1:0], 3'b000} +: 8] <= data_byte;
					else if (hdr_pos_q >= 5'd16 && hdr_pos_q < 5'd20)
						dlen_q[{hdr_pos_q[1:0], 3'b000} +: 8] <= data_byte;
					else if (hdr_pos_q >= 5'd20)
						dcks_q[{hdr_pos_q[1:0], 3'b000} +: 8] <= data_byte;
				end
				if (cmd.take_byte && hdr_done) count_q <= count_q + 64'd1;
				if ((cmd.take_byte && hdr_done) || cmd.pad_shift)
					blk_pos_q <= blk_pos_q + 6'd1;
				if (cmd.finish)
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				if (cmd.load2)
					for (int i = 0; i < 8; i++) h_q[i] <= SHA_INIT[i];
			end
		end
	end

	// working variables and block window, no reset needed
	always_ff @(posedge clk) begin
		if ((cmd.take_byte && hdr_done) || cmd.pad_shift) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			w_q[15] <= {w_q[15][23:0], shift_byte};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end else if (cmd.load2) begin
			for (int i = 0; i < 8; i++) w_q[i] <= h_q[i];
			w_q[8] <= 32'h80000000;
			for (int i = 9; i < 15; i++) w_q[i] <= 32'd0;
			w_q[15] <= 32'd256;
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.load2) begin
			for (int i = 0; i < 8; i++) v_q[i] <= SHA_INIT[i];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.load_out) begin
			status <= cmd.status;
			payload_length <= (cmd.status == ST_SHORT) ? 32'd0 : dlen_q;
			received_checksum <= (cmd.status == ST_SHORT) ? 32'd0 : dcks_q;
			computed_checksum <= (cmd.status == ST_GOOD || cmd.status == ST_CKS)
				? cks_calc : 32'd0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/mhc_ctrl.sv =====
`default_nettype none
module mhc_ctrl
	import mhc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic last_byte,
	output logic out_valid,
	input wire logic out_ready,
	input wire mhc_sts_t sts,
	output mhc_cmd_t cmd
);

	localparam logic [3:0] S_ACC = 4'd0;
	localparam logic [3:0] S_COMP = 4'd1;
	localparam logic [3:0] S_FIN = 4'd2;
	localparam logic [3:0] S_P80 = 4'd3;
	localparam logic [3:0] S_PZ = 4'd4;
	localparam logic [3:0] S_PL = 4'd5;
	localparam logic [3:0] S_LOAD2 = 4'd6;
	localparam logic [3:0] S_CHECK = 4'd7;
	localparam logic [3:0] S_RES = 4'd8;

	localparam logic [1:0] RET_ACC = 2'd0;
	localparam logic [1:0] RET_CHECK = 2'd1;
	localparam logic [1:0] RET_PZ = 2'd2;
	localparam logic [1:0] RET_LOAD2 = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;
	logic hashed_q, hashed_d;
	logic [2:0] status_q, status_d;
	logic out_valid_q, out_valid_d;

	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		rnd_d = '0;
		hashed_d = hashed_q;
		status_d = status_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready = 1'b0;
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.status = status_q;
		unique case (state_q)
			S_ACC: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					if (sts.hdr_done && sts.blk_last) begin
						cmd.start = 1'b1;
						state_d = S_COMP;
						ret_d = last_byte ? RET_CHECK : RET_ACC;
					end else if (last_byte) begin
						state_d = S_CHECK;
					end
				end
			end
			S_COMP: begin
				cmd.round = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == 6'd63) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				unique case (ret_q)
					RET_ACC: state_d = S_ACC;
					RET_CHECK: state_d = S_CHECK;
					RET_PZ: state_d = S_PZ;
					RET_LOAD2: state_d = S_LOAD2;
					default: state_d = S_ACC;
				endcase
			end
			S_P80: begin
				cmd.pad_shift = 1'b1;
				cmd.pad_sel = PAD_80;
				state_d = S_PZ;
				if (sts.blk_last) begin
					cmd.start = 1'b1;
					state_d = S_COMP;
					ret_d = RET_PZ;
				end
			end
			S_PZ: begin
				if (sts.blk_at_len) begin
					state_d = S_PL;
				end else begin
					cmd.pad_shift = 1'b1;
					cmd.pad_sel = PAD_ZERO;
					if (sts.blk_last) begin
						cmd.start = 1'b1;
						state_d = S_COMP;
						ret_d = RET_PZ;
					end
				end
			end
			S_PL: begin
				cmd.pad_shift = 1'b1;
				cmd.pad_sel = PAD_LEN;
				if (sts.blk_last) begin
					cmd.start = 1'b1;
					state_d = S_COMP;
					ret_d = RET_LOAD2;
				end
			end
			S_LOAD2: begin
				cmd.load2 = 1'b1;
				hashed_d = 1'b1;
				state_d = S_COMP;
				ret_d = RET_CHECK;
			end
			S_CHECK: begin
				state_d = S_RES;
				if (sts.short_hdr) status_d = ST_SHORT;
				else if (sts.magic_bad) status_d = ST_MAGIC;
				else if (sts.len_bad) status_d = ST_LENGTH;
				else if (sts.empty || hashed_q) status_d = sts.cks_match ? ST_GOOD : ST_CKS;
				else state_d = S_P80;
			end
			S_RES: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					cmd.clear = 1'b1;
					out_valid_d = 1'b1;
					hashed_d = 1'b0;
					state_d = S_ACC;
				end
			end
			default: state_d = S_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			ret_q <= RET_ACC;
			rnd_q <= '0;
			hashed_q <= 1'b0;
			status_q <= ST_GOOD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			rnd_q <= rnd_d;
			hashed_q <= hashed_d;
			status_q <= status_d;
			out_valid_q <= out_valid_d;
		end
	end

`ifndef SYNTHESIS
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_byte |=> !in_ready)
		else $error("input still open after last byte");
	a_result_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_RES))
		else $error("result raised outside result state");
	a_fin_after_64: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> $past(state_q == S_COMP && rnd_q == 6'd63))
		else $error("compression finished early");
`endif

endmodule
`default_nettype wire

// ===== sv/message_header_checker.sv =====
// message header checker: takes one message a byte at a time on the input
// channel (data_byte, last_byte with in_valid/in_ready), 24 header bytes
// then payload, and gives one result transaction per message on the output
// channel (status, payload_length, received_checksum, computed_checksum).
// network_magic is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, which the block itself does not enforce.
// payload bytes follow the header; every 64th payload byte completes a
// block, compressed at one SHA-256 round per cycle in the shared round
// unit plus the final add, the block load overlapping the byte itself.
// at the last byte a message with a payload that passes the header, magic
// and length checks is padded (0x80, zeros, then the 64-bit bit length)
// and runs the second hash; others skip hashing. the result sits in an
// output register, so the next message is taken while it waits. if the
// receiver stalls with a result pending, the next message runs until its
// own last byte and then holds until the slot frees. reset clears all
// message state, loads the main network magic and drops out_valid.
`default_nettype none
module message_header_checker
	import mhc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire logic [31:0] cfg_wr_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] data_byte,
	input wire logic last_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [31:0] payload_length,
	output logic [31:0] received_checksum,
	output logic [31:0] computed_checksum
);

	// command and status between sequencer and hash datapath
	mhc_cmd_t cmd;
	mhc_sts_t sts;

	mhc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts(sts),
		.cmd(cmd)
	);

	mhc_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.data_byte(data_byte),
		.cmd(cmd),
		.sts(sts),
		.status(status),
		.payload_length(payload_length),
		.received_checksum(received_checksum),
		.computed_checksum(computed_checksum)
	);

endmodule
`default_nettype wire
